>>> hdl/xpbd_distance_constraint_defines.svh
// ----------------------------------------------------------------------------
// XPBD distance constraint assertion macros
// Concurrent check wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef XPBD_DISTANCE_CONSTRAINT_DEFINES_SVH
`define XPBD_DISTANCE_CONSTRAINT_DEFINES_SVH

// same-cycle implication
`define XDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xdc check failed");

// next-cycle implication
`define XDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xdc check failed");

`endif

>>> hdl/xdc_pkg.sv
// ----------------------------------------------------------------------------
// XPBD distance constraint package
// Word types, register codes and shared unit command format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xdc_pkg;

   localparam int ALU_W = 128;
   localparam int ALU_B = 64;
   localparam int CNT_W = 7;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_COMPLIANCE = 1'b0;
   localparam logic REG_TIME_STEP  = 1'b1;

   localparam logic [31:0] TIME_STEP_RESET = 32'h0001_0000;
   localparam logic [47:0] STEP_CAP        = 48'hFFFF_FFFF_FFFF;
   localparam logic [39:0] CONV_CAP        = 40'hFF_FFFF_FFFF;
   localparam logic [30:0] MODALPH_CAP     = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic [31:0]        mass_first;
      logic [31:0]        mass_second;
      logic               pinned_first;
      logic               pinned_second;
      logic [31:0]        rest_length;
      logic signed [31:0] multiplier_in;
      logic               restart_sum;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] new_first_x;
      logic signed [31:0] new_first_y;
      logic signed [31:0] new_second_x;
      logic signed [31:0] new_second_y;
      logic signed [31:0] multiplier_out;
      logic [39:0]        convergence_sum;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] compliance;
      logic [31:0] time_step;
   } cfg_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [ALU_W-1:0]  a;
      logic [ALU_B-1:0]  b;
      logic [CNT_W-1:0]  count;
   } alu_cmd_type;

endpackage

>>> hdl/xdc_alu.sv
// ----------------------------------------------------------------------------
// XPBD distance constraint shared unit
// Bit-serial multiply, restoring divide and digit-by-digit square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xdc_alu import xdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  alu_cmd_type       cmd,
   output logic [ALU_W-1:0]  result,
   output logic              done
);

   alu_op_type        op_ff;
   logic [ALU_W-1:0]  x_ff;
   logic [ALU_B-1:0]  y_ff;
   logic [ALU_W-1:0]  acc_ff;
   logic [ALU_B-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ALU_W-1:0]  add_sum;
   logic [ALU_B:0]    lhs;
   logic [ALU_B:0]    rhs;
   logic [ALU_B+1:0]  diff;
   logic              ge;

   always_comb begin
      add_sum = acc_ff + (y_ff[0] ? x_ff : '0);
      if (op_ff == ALU_SQRT) begin
         lhs = {rem_ff[ALU_B-2:0], x_ff[ALU_W-1 -: 2]};
         rhs = {y_ff[ALU_B-2:0], 2'b01};
      end else begin
         lhs = {rem_ff, x_ff[ALU_W-1]};
         rhs = {1'b0, y_ff};
      end
      diff = {1'b0, lhs} - {1'b0, rhs};
      ge   = ~diff[ALU_B+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= ALU_MUL;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= cmd.count;
         op_ff   <= cmd.op;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != 1);
         done_ff <= (cnt_ff == 1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= cmd.a;
         y_ff   <= cmd.b;
         acc_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               acc_ff <= add_sum;
               x_ff   <= {x_ff[ALU_W-2:0], 1'b0};
               y_ff   <= {1'b0, y_ff[ALU_B-1:1]};
            end
            ALU_DIV: begin
               rem_ff <= ge ? diff[ALU_B-1:0] : lhs[ALU_B-1:0];
               x_ff   <= {x_ff[ALU_W-2:0], ge};
            end
            ALU_SQRT: begin
               rem_ff <= ge ? diff[ALU_B-1:0] : lhs[ALU_B-1:0];
               y_ff   <= {y_ff[ALU_B-2:0], ge};
               x_ff   <= {x_ff[ALU_W-3:0], 2'b00};
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (op_ff)
         ALU_MUL:  result = acc_ff;
         ALU_DIV:  result = x_ff;
         ALU_SQRT: result = {{(ALU_W-ALU_B){1'b0}}, y_ff};
         default:  result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

>>> hdl/xdc_csr.sv
// ----------------------------------------------------------------------------
// XPBD distance constraint registers
// Compliance and time step behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xdc_csr import xdc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [31:0] compliance_ff;
   logic [31:0] time_step_ff;
   logic        reg_idx;

   assign reg_idx = paddr[2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         compliance_ff <= '0;
         time_step_ff  <= TIME_STEP_RESET;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_COMPLIANCE: compliance_ff <= pwdata;
            REG_TIME_STEP:  time_step_ff  <= pwdata;
            default:        compliance_ff <= compliance_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COMPLIANCE: prdata = compliance_ff;
         REG_TIME_STEP:  prdata = time_step_ff;
         default:        prdata = '0;
      endcase
   end

   assign cfg.compliance = compliance_ff;
   assign cfg.time_step  = time_step_ff;

endmodule

>>> hdl/xpbd_distance_constraint.sv
// ----------------------------------------------------------------------------
// XPBD distance constraint projection
// Sequencer around one shared bit-serial unit; one constraint at a time.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  req     | req_valid/req_ready/req_data   | one constraint word in
//  rsp     | rsp_valid/rsp_ready/rsp_data   | one corrected word out
//  csr     | psel/penable/pwrite/paddr/...  | compliance, time step
//
//  From acceptance to the result register, every product, quotient and
//  root goes through the shared unit one bit (root: one digit) per cycle;
//  each operation passes the S_ISSUE and S_WAIT states. A zero time step
//  or a zero mass skips its divide; pinned or coinciding points and zero
//  corrections skip their steps. req_ready returns as rsp_valid is set.
//  reset is synchronous: it clears the sequencer, the sum and the registers.
//  A finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xpbd_distance_constraint import xdc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_ISSUE,
      S_WAIT,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_TSQ,
      ST_MODALPH,
      ST_INV1,
      ST_INV2,
      ST_LAMP,
      ST_DELTA,
      ST_F1,
      ST_F2,
      ST_MVMUL,
      ST_MVDIV,
      ST_CONV1,
      ST_CONV2
   } step_type;

   function automatic logic [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647)       return 32'h7FFF_FFFF;
      else if (v < -50'sd2147483648) return 32'h8000_0000;
      else                           return v[31:0];
   endfunction

   cfg_type            cfg;
   logic               alu_start;
   alu_cmd_type        alu_cmd;
   logic [ALU_W-1:0]   alu_res;
   logic               alu_done;

   state_type          state_ff;
   step_type           step_ff;
   step_type           step_in;
   logic [1:0]         coord_ff;
   req_word_type       req_ff;
   logic [32:0]        ax_ff;
   logic [32:0]        ay_ff;
   logic               sx_ff;
   logic               sy_ff;
   logic               huge_ff;
   logic               zero_dir_ff;
   logic [63:0]        sq_ff;
   logic [32:0]        dist_ff;
   logic signed [33:0] c_ff;
   logic [63:0]        tsq_ff;
   logic [30:0]        modalph_ff;
   logic [32:0]        i1_ff;
   logic [32:0]        i2_ff;
   logic signed [63:0] s_ff;
   logic [34:0]        den_ff;
   logic [47:0]        d_ff;
   logic               dneg_ff;
   logic [47:0]        f1_ff;
   logic [47:0]        f2_ff;
   logic [80:0]        prod_ff;
   logic [31:0]        new_ff [4];
   logic [39:0]        t1_ff;
   logic [39:0]        conv_ff;
   rsp_word_type       rsp_ff;
   logic               rsp_valid_ff;

   logic signed [32:0] dx_w;
   logic signed [32:0] dy_w;
   logic [31:0]        ax_s;
   logic [31:0]        ay_s;
   logic [31:0]        lam_mag;
   logic [63:0]        s_mag;
   logic [47:0]        mv_f;
   logic [32:0]        mv_mag;
   logic [31:0]        mv_coord;
   logic               mv_neg;
   logic               mv_skip;
   logic               skip_now;
   logic [47:0]        q48;
   logic signed [49:0] mv_sum;
   logic [32:0]        dist_in;
   logic signed [63:0] s_in;
   logic [63:0]        lam_prod;
   logic [39:0]        conv_base;
   logic [41:0]        sum_in;
   logic [39:0]        t2_w;
   logic signed [49:0] lam_sum;

   xdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   xdc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .cmd    (alu_cmd),
      .result (alu_res),
      .done   (alu_done)
   );

   always_comb begin
      dx_w    = $signed({req_ff.first_x[31], req_ff.first_x})
              - $signed({req_ff.second_x[31], req_ff.second_x});
      dy_w    = $signed({req_ff.first_y[31], req_ff.first_y})
              - $signed({req_ff.second_y[31], req_ff.second_y});
      ax_s    = huge_ff ? ax_ff[32:1] : ax_ff[31:0];
      ay_s    = huge_ff ? ay_ff[32:1] : ay_ff[31:0];
      lam_mag = req_ff.multiplier_in[31] ? (32'd0 - req_ff.multiplier_in)
                                         : req_ff.multiplier_in;
      s_mag   = s_ff[63] ? (64'd0 - s_ff) : s_ff;
      q48     = (alu_res[ALU_W-1:48] != '0) ? STEP_CAP : alu_res[47:0];
      t2_w    = (alu_res[ALU_W-1:56] != '0) ? CONV_CAP : alu_res[55:16];
      dist_in = huge_ff ? {alu_res[31:0], 1'b0} : {1'b0, alu_res[31:0]};
      lam_prod = req_ff.multiplier_in[31] ? (64'd0 - {1'b0, alu_res[62:0]})
                                          : {1'b0, alu_res[62:0]};
      s_in    = $signed({{14{c_ff[33]}}, c_ff, 16'b0}) + $signed(lam_prod);
      conv_base = req_ff.restart_sum ? '0 : conv_ff;
      sum_in  = {2'b00, conv_base} + {2'b00, t1_ff} + {2'b00, t2_w};
      lam_sum = $signed({{18{req_ff.multiplier_in[31]}}, req_ff.multiplier_in})
              + (dneg_ff ? -$signed({2'b00, d_ff}) : $signed({2'b00, d_ff}));
   end

   always_comb begin
      case (coord_ff)
         2'd0: begin
            mv_f = f1_ff; mv_mag = ax_ff; mv_coord = req_ff.first_x;
            mv_neg = sx_ff ^ dneg_ff;
         end
         2'd1: begin
            mv_f = f1_ff; mv_mag = ay_ff; mv_coord = req_ff.first_y;
            mv_neg = sy_ff ^ dneg_ff;
         end
         2'd2: begin
            mv_f = f2_ff; mv_mag = ax_ff; mv_coord = req_ff.second_x;
            mv_neg = ~(sx_ff ^ dneg_ff);
         end
         default: begin
            mv_f = f2_ff; mv_mag = ay_ff; mv_coord = req_ff.second_y;
            mv_neg = ~(sy_ff ^ dneg_ff);
         end
      endcase
      mv_skip = (mv_f == '0) || (mv_mag == '0);
      mv_sum  = $signed({{18{mv_coord[31]}}, mv_coord})
              + (mv_neg ? -$signed({2'b00, q48}) : $signed({2'b00, q48}));
   end

   always_comb begin
      alu_cmd.op    = ALU_MUL;
      alu_cmd.a     = '0;
      alu_cmd.b     = '0;
      alu_cmd.count = 7'd32;
      skip_now      = 1'b0;
      case (step_ff)
         ST_SQX: begin
            alu_cmd.a = {96'b0, ax_s};
            alu_cmd.b = {32'b0, ax_s};
         end
         ST_SQY: begin
            alu_cmd.a = {96'b0, ay_s};
            alu_cmd.b = {32'b0, ay_s};
         end
         ST_ROOT: begin
            alu_cmd.op = ALU_SQRT;
            alu_cmd.a  = {sq_ff, 64'b0};
         end
         ST_TSQ: begin
            alu_cmd.a = {96'b0, cfg.time_step};
            alu_cmd.b = {32'b0, cfg.time_step};
         end
         ST_MODALPH: begin
            alu_cmd.op    = ALU_DIV;
            alu_cmd.a     = {cfg.compliance, 96'b0};
            alu_cmd.b     = tsq_ff;
            alu_cmd.count = 7'd64;
            skip_now      = (tsq_ff == '0);
         end
         ST_INV1: begin
            alu_cmd.op    = ALU_DIV;
            alu_cmd.a     = {1'b1, 127'b0};
            alu_cmd.b     = {32'b0, req_ff.mass_first};
            alu_cmd.count = 7'd33;
            skip_now      = (req_ff.mass_first == '0);
         end
         ST_INV2: begin
            alu_cmd.op    = ALU_DIV;
            alu_cmd.a     = {1'b1, 127'b0};
            alu_cmd.b     = {32'b0, req_ff.mass_second};
            alu_cmd.count = 7'd33;
            skip_now      = (req_ff.mass_second == '0);
         end
         ST_LAMP: begin
            alu_cmd.a = {97'b0, modalph_ff};
            alu_cmd.b = {32'b0, lam_mag};
         end
         ST_DELTA: begin
            alu_cmd.op    = ALU_DIV;
            alu_cmd.a     = {s_mag, 64'b0};
            alu_cmd.b     = {29'b0, den_ff};
            alu_cmd.count = 7'd64;
         end
         ST_F1: begin
            alu_cmd.a     = {80'b0, d_ff};
            alu_cmd.b     = {31'b0, i1_ff};
            alu_cmd.count = 7'd33;
            skip_now      = zero_dir_ff || req_ff.pinned_first;
         end
         ST_F2: begin
            alu_cmd.a     = {80'b0, d_ff};
            alu_cmd.b     = {31'b0, i2_ff};
            alu_cmd.count = 7'd33;
            skip_now      = zero_dir_ff || req_ff.pinned_second;
         end
         ST_MVMUL: begin
            alu_cmd.a     = {80'b0, mv_f};
            alu_cmd.b     = {31'b0, mv_mag};
            alu_cmd.count = 7'd33;
            skip_now      = mv_skip;
         end
         ST_MVDIV: begin
            alu_cmd.op    = ALU_DIV;
            alu_cmd.a     = {prod_ff, 47'b0};
            alu_cmd.b     = {31'b0, dist_ff};
            alu_cmd.count = 7'd81;
         end
         ST_CONV1: begin
            alu_cmd.a     = {80'b0, f1_ff};
            alu_cmd.b     = {16'b0, d_ff};
            alu_cmd.count = 7'd48;
         end
         ST_CONV2: begin
            alu_cmd.a     = {80'b0, f2_ff};
            alu_cmd.b     = {16'b0, d_ff};
            alu_cmd.count = 7'd48;
         end
         default: begin
            skip_now = 1'b0;
         end
      endcase
      alu_start = (state_ff == S_ISSUE) && !skip_now;
   end

   always_comb begin
      case (step_ff)
         ST_SQX:     step_in = ST_SQY;
         ST_SQY:     step_in = ST_ROOT;
         ST_ROOT:    step_in = ST_TSQ;
         ST_TSQ:     step_in = ST_MODALPH;
         ST_MODALPH: step_in = ST_INV1;
         ST_INV1:    step_in = ST_INV2;
         ST_INV2:    step_in = ST_LAMP;
         ST_LAMP:    step_in = ST_DELTA;
         ST_DELTA:   step_in = ST_F1;
         ST_F1:      step_in = ST_F2;
         ST_F2:      step_in = ST_MVMUL;
         ST_MVMUL: begin
            if (!skip_now)          step_in = ST_MVDIV;
            else if (coord_ff == 3) step_in = ST_CONV1;
            else                    step_in = ST_MVMUL;
         end
         ST_MVDIV:   step_in = (coord_ff == 3) ? ST_CONV1 : ST_MVMUL;
         ST_CONV1:   step_in = ST_CONV2;
         default:    step_in = ST_SQX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_SQX;
         coord_ff     <= '0;
         conv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               ax_ff       <= dx_w[32] ? (33'd0 - dx_w) : dx_w;
               ay_ff       <= dy_w[32] ? (33'd0 - dy_w) : dy_w;
               sx_ff       <= dx_w[32];
               sy_ff       <= dy_w[32];
               huge_ff     <= (dx_w >= 33'sd2147483648) || (dx_w <= -33'sd2147483648)
                           || (dy_w >= 33'sd2147483648) || (dy_w <= -33'sd2147483648);
               zero_dir_ff <= (dx_w == '0) && (dy_w == '0);
               step_ff     <= ST_SQX;
               coord_ff    <= '0;
               state_ff    <= S_ISSUE;
            end
            S_ISSUE: begin
               if (skip_now) begin
                  case (step_ff)
                     ST_MODALPH: modalph_ff <= MODALPH_CAP;
                     ST_INV1:    i1_ff      <= {1'b1, 32'b0};
                     ST_INV2:    i2_ff      <= {1'b1, 32'b0};
                     ST_F1:      f1_ff      <= '0;
                     ST_F2:      f2_ff      <= '0;
                     ST_MVMUL: begin
                        new_ff[coord_ff] <= mv_coord;
                        coord_ff         <= coord_ff + 1'b1;
                     end
                     default:    modalph_ff <= modalph_ff;
                  endcase
                  step_ff <= step_in;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (alu_done) begin
                  case (step_ff)
                     ST_SQX:  sq_ff  <= alu_res[63:0];
                     ST_SQY:  sq_ff  <= sq_ff + alu_res[63:0];
                     ST_ROOT: begin
                        dist_ff <= dist_in;
                        c_ff    <= $signed({1'b0, dist_in}) - $signed({2'b00, req_ff.rest_length});
                     end
                     ST_TSQ:  tsq_ff <= alu_res[63:0];
                     ST_MODALPH: modalph_ff <= (alu_res[63:31] != '0) ? MODALPH_CAP
                                                                      : alu_res[30:0];
                     ST_INV1: i1_ff <= alu_res[32:0];
                     ST_INV2: i2_ff <= alu_res[32:0];
                     ST_LAMP: begin
                        s_ff    <= s_in;
                        dneg_ff <= !s_in[63] && (s_in != '0);
                        den_ff  <= {2'b00, i1_ff} + {2'b00, i2_ff} + {4'b0000, modalph_ff};
                     end
                     ST_DELTA: d_ff <= q48;
                     ST_F1: f1_ff <= (alu_res[ALU_W-1:64] != '0) ? STEP_CAP : alu_res[63:16];
                     ST_F2: f2_ff <= (alu_res[ALU_W-1:64] != '0) ? STEP_CAP : alu_res[63:16];
                     ST_MVMUL: prod_ff <= alu_res[80:0];
                     ST_MVDIV: begin
                        new_ff[coord_ff] <= sat32(mv_sum);
                        coord_ff         <= coord_ff + 1'b1;
                     end
                     ST_CONV1: t1_ff <= t2_w;
                     ST_CONV2: conv_ff <= (sum_in > {2'b00, CONV_CAP}) ? CONV_CAP
                                                                       : sum_in[39:0];
                     default: sq_ff <= sq_ff;
                  endcase
                  step_ff  <= step_in;
                  state_ff <= (step_ff == ST_CONV2) ? S_OUT : S_ISSUE;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.new_first_x     <= new_ff[0];
                  rsp_ff.new_first_y     <= new_ff[1];
                  rsp_ff.new_second_x    <= new_ff[2];
                  rsp_ff.new_second_y    <= new_ff[3];
                  rsp_ff.multiplier_out  <= sat32(lam_sum);
                  rsp_ff.convergence_sum <= conv_ff;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/xdc_checker.sv
// ----------------------------------------------------------------------------
// XPBD distance constraint port checker
// Handshake and sequencing checks on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xpbd_distance_constraint_defines.svh"

module xdc_checker import xdc_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input rsp_word_type  rsp_data
);

   `XDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `XDC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `XDC_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(!req_ready))
   `XDC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind xpbd_distance_constraint xdc_checker u_xdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/xpbd_distance_constraint_tb.sv
// ----------------------------------------------------------------------------
// XPBD distance constraint testbench
// Drives constraint words through the block under several compliance and
// time step settings, predicts every corrected word and the running
// convergence sum, and checks each output word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xpbd_distance_constraint_tb;
   import xdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES = 5000;
   localparam int DRAIN_CYCLES = 1500;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   logic [31:0] compliance_q;
   logic [31:0] time_step_q;
   logic [39:0] conv_total_q;
   int error_count;
   int idle_count;
   logic calm;
   logic hold_go;
   int hold_cnt;

   xpbd_distance_constraint dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b,
                                                      longint unsigned cap);
      logic [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> 16;
      return (p > cap) ? cap : p[63:0];
   endfunction

   function automatic logic [31:0] shift_point(longint coord, longint unsigned f,
                                               longint unsigned mag, bit neg,
                                               longint unsigned span);
      logic [127:0] p;
      longint c;
      if (f == 0 || mag == 0 || span == 0) return sat32(coord);
      p = ({64'b0, f} * {64'b0, mag}) / span;
      c = (p > STEP_CAP) ? longint'(STEP_CAP) : longint'(p[63:0]);
      return sat32(neg ? coord - c : coord + c);
   endfunction

   function automatic longint unsigned inverse_mass(logic [31:0] m);
      return (m == 0) ? 64'h1_0000_0000 : 64'h1_0000_0000 / m;
   endfunction

   function automatic rsp_word_type project_constraint(req_word_type w);
      rsp_word_type r;
      longint x1, y1, x2, y2, dx, dy, c, num, lam, sd;
      longint unsigned ax, ay, span, tsq, modalph, den, d, f1, f2, i1, i2, mag;
      logic [63:0] sum;
      bit neg, zero_dir;
      x1 = longint'(w.first_x);
      y1 = longint'(w.first_y);
      x2 = longint'(w.second_x);
      y2 = longint'(w.second_y);
      lam = longint'(w.multiplier_in);
      i1 = inverse_mass(w.mass_first);
      i2 = inverse_mass(w.mass_second);
      dx = x1 - x2;
      dy = y1 - y2;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      zero_dir = (ax | ay) == 0;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
         span = int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1)) << 1;
      else
         span = int_sqrt(ax * ax + ay * ay);
      c = longint'(span) - longint'({32'b0, w.rest_length});
      tsq = {32'b0, time_step_q} * {32'b0, time_step_q};
      modalph = (tsq == 0) ? MODALPH_CAP : ({32'b0, compliance_q} << 32) / tsq;
      if (modalph > MODALPH_CAP) modalph = MODALPH_CAP;
      num = -c * 65536 - longint'(modalph) * lam;
      den = i1 + i2 + modalph;
      neg = num < 0;
      mag = neg ? -num : num;
      d = mag / den;
      if (d > STEP_CAP) d = STEP_CAP;
      sd = neg ? -longint'(d) : longint'(d);
      f1 = (zero_dir || w.pinned_first) ? 0 : scaled_product(i1, d, STEP_CAP);
      f2 = (zero_dir || w.pinned_second) ? 0 : scaled_product(i2, d, STEP_CAP);
      r.new_first_x = shift_point(x1, f1, ax, (dx < 0) != neg, span);
      r.new_first_y = shift_point(y1, f1, ay, (dy < 0) != neg, span);
      r.new_second_x = shift_point(x2, f2, ax, (dx < 0) == neg, span);
      r.new_second_y = shift_point(y2, f2, ay, (dy < 0) == neg, span);
      r.multiplier_out = sat32(lam + sd);
      sum = w.restart_sum ? 64'd0 : {24'b0, conv_total_q};
      sum = sum + scaled_product(f1, d, CONV_CAP) + scaled_product(f2, d, CONV_CAP);
      if (sum > CONV_CAP) sum = CONV_CAP;
      conv_total_q = sum[39:0];
      r.convergence_sum = sum[39:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   function automatic void add_pending(req_word_type w);
      pending_words = {pending_words, w};
   endfunction

   // driver and input-side prediction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_words = {expected_words, project_constraint(req_data)};
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_go) begin
         hold_cnt <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 34;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_data[63:0], '0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.new_first_x !== want.new_first_x)
               report_mismatch("new_first_x", rsp_data.new_first_x, want.new_first_x);
            if (rsp_data.new_first_y !== want.new_first_y)
               report_mismatch("new_first_y", rsp_data.new_first_y, want.new_first_y);
            if (rsp_data.new_second_x !== want.new_second_x)
               report_mismatch("new_second_x", rsp_data.new_second_x, want.new_second_x);
            if (rsp_data.new_second_y !== want.new_second_y)
               report_mismatch("new_second_y", rsp_data.new_second_y, want.new_second_y);
            if (rsp_data.multiplier_out !== want.multiplier_out)
               report_mismatch("multiplier_out", rsp_data.multiplier_out,
                               want.multiplier_out);
            if (rsp_data.convergence_sum !== want.convergence_sum)
               report_mismatch("convergence_sum", rsp_data.convergence_sum,
                               want.convergence_sum);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_register(logic idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_ADDR_W'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_COMPLIANCE) compliance_q = value;
      else time_step_q = value;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(3))
         0: return $urandom_range(32'hFFFF_FFFF, 1);
         1: return $urandom_range(32'h0000_FFFF, 1);
         default: return $urandom_range(32'h0010_0000, 32'h0000_4000);
      endcase
   endfunction

   function automatic req_word_type rand_word();
      req_word_type w;
      w.first_x = rand_coord();
      w.first_y = rand_coord();
      if ($urandom_range(9) == 0) begin
         w.second_x = w.first_x;
         w.second_y = w.first_y;
      end else begin
         w.second_x = ($urandom_range(2) == 0) ? rand_coord()
                    : w.first_x + $urandom_range(32'h0008_0000) - 32'h0004_0000;
         w.second_y = ($urandom_range(2) == 0) ? rand_coord()
                    : w.first_y + $urandom_range(32'h0008_0000) - 32'h0004_0000;
      end
      w.mass_first = rand_mass();
      w.mass_second = rand_mass();
      w.pinned_first = $urandom_range(3) == 0;
      w.pinned_second = $urandom_range(3) == 0;
      w.rest_length = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0008_0000);
      w.multiplier_in = ($urandom_range(3) == 0) ? $urandom
                      : $urandom_range(32'h0002_0000) - 32'h0001_0000;
      w.restart_sum = $urandom_range(7) == 0;
      return w;
   endfunction

   function automatic req_word_type make_word(logic [31:0] x1, logic [31:0] y1,
                                              logic [31:0] x2, logic [31:0] y2,
                                              logic [31:0] m1, logic [31:0] m2,
                                              logic p1, logic p2, logic [31:0] rest,
                                              logic [31:0] lam, logic rs);
      req_word_type w;
      w = '{x1, y1, x2, y2, m1, m2, p1, p2, rest, lam, rs};
      return w;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_data = '0;
      calm = 1'b0;
      hold_go = 1'b0;
      error_count = 0;
      compliance_q = '0;
      time_step_q = TIME_STEP_RESET;
      conv_total_q = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, coinciding and pinned points, huge separation
      add_pending(make_word(32'h0001_0000, 0, 0, 0, 32'h0001_0000,
                            32'h0001_0000, 0, 0, 0, 0, 1));
      add_pending(make_word(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h0001_0000,
                            32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0));
      add_pending(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 1, 1, 0, 0, 0, 32'h7FFF_FFFF, 0));
      add_pending(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                            32'hFFFF_FFFF, 32'h8000_0000, 0));
      add_pending(make_word(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                            32'h1234_5678, 32'h0001_0000, 32'h0001_0000, 0, 0,
                            32'h0002_0000, 32'h0001_0000, 0));
      add_pending(make_word(0, 0, 0, 0, 1, 32'hFFFF_FFFF, 1, 1,
                            32'hFFFF_FFFF, 32'h7FFF_FFFF, 1));
      add_pending(make_word(32'h0005_0000, 0, 0, 32'h0005_0000, 32'h0001_0000,
                            32'h0001_0000, 1, 0, 32'h0001_0000, 0, 0));
      add_pending(make_word(32'h0005_0000, 0, 0, 32'h0005_0000, 32'h0001_0000,
                            32'h0001_0000, 0, 1, 32'h0010_0000, 0, 0));
      add_pending(make_word(32'h0005_0000, 0, 0, 32'h0005_0000, 32'h0001_0000,
                            32'h0001_0000, 1, 1, 32'h0010_0000, 32'hFFFF_0000,
                            0));
      add_pending(make_word(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 1, 1, 0, 0,
                            0, 0, 0));
      add_pending(make_word(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 1, 0, 0,
                            0, 32'h8000_0000, 0));
      add_pending(make_word(1, 0, 0, 0, 1, 1, 0, 0, 32'hFFFF_FFFF, 0, 0));
      add_pending(make_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0001_0000,
                            1, 0, 0, 0, 32'h0000_8000, 0));
      for (int i = 0; i < 120; i++) add_pending(rand_word());
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         case (phase)
            0: begin
               write_register(REG_COMPLIANCE, 32'h0000_8000);
               write_register(REG_TIME_STEP, 32'h0000_1000);
            end
            1: begin
               write_register(REG_COMPLIANCE, 32'hFFFF_FFFF);
               write_register(REG_TIME_STEP, 32'h0000_0001);
            end
            2: begin
               write_register(REG_COMPLIANCE, 32'h0000_0001);
               write_register(REG_TIME_STEP, 32'hFFFF_FFFF);
            end
            default: begin
               write_register(REG_COMPLIANCE, $urandom);
               write_register(REG_TIME_STEP, $urandom_range(32'h0004_0000, 1));
            end
         endcase
         calm <= (phase == 1);
         for (int i = 0; i < 120; i++) add_pending(rand_word());
         if (phase == 2) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
